FILE: hdl/mhwd_pkg.sv
// shared constants for the multi-hit window digitizer
// register indexes, reset values, default parameters and iteration counts
// no dependencies
package mhwd_pkg;

	localparam int SENSOR_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 16;

	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHARGE_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_ORIGIN         = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD_TIME_MODE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_LENGTH         = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_SCALE          = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHARGE_SCALE        = 3'd6;

	localparam logic [19:0] THRESHOLD_RST = 20'd640;
	localparam logic [31:0] ORIGIN_RST    = 32'd0;
	localparam logic        TMODE_RST     = 1'b1;
	localparam logic [15:0] WINDOW_RST    = 16'd800;
	localparam logic [15:0] DEAD_RST      = 16'd160;
	localparam logic [15:0] TSCALE_RST    = 16'd2560;
	localparam logic [15:0] CSCALE_RST    = 16'd2560;

	// one quotient bit per cycle over a 72 bit dividend, two input bits per root step
	localparam int DIV_STEPS  = 72;
	localparam int SQRT_STEPS = 32;
	localparam int CNT_BITS   = 7;

	// one time digit in 1/16 ns is 4096 / time_scale
	localparam logic [15:0] DIGIT_NUM = 16'd4096;

	localparam logic [47:0] M1_MAX = 48'hFFFF_FFFF_FFFF;

endpackage

FILE: hdl/multi_hit_window_digitizer_top.sv
// multi-hit window digitizer: integrates impulses into hits and digitizes them
// one iterative divider, one square root stepper and one shared multiplier
// depends on mhwd_pkg
//
// usage: impulses of one sensor arrive time ordered on the input channel
// (in_valid / in_stall); an end item (kind = 1) closes the open hit. digitized
// hits, or refusals of impulses from a foreign sensor, leave on the output
// channel (out_valid / out_stall). registers are written on the cfg channel
// (cfg_valid / cfg_ready, always ready); the user writes them only while the
// block is idle, the block itself does not enforce it. one item at a time;
// in_stall is high until the item is done. an impulse inside the window passes
// S_ACC1, S_ACC2 and S_ACC3, one opening a hit S_OPEN before them. closing a
// hit that passes the threshold runs the 72 step divider for the digit size,
// then in weighted mean mode two more 72 step divisions, two multiplier passes
// and a 32 step root; a late impulse that closed the hit then opens a new one.
// the multiplier is shared by integration and digitizing, one product a cycle.
// results sit in an output register; the next item is taken while a result
// waits, but a new result holds in its emit step until the register is free.
// reset loads the configuration reset values and leaves no hit open.
module multi_hit_window_digitizer_top #(
	parameter int SENSOR_BITS = mhwd_pkg::SENSOR_BITS_DEF,
	parameter int OFFSET_BITS = mhwd_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mhwd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [15:0]                       sensor_id,
	input  logic [31:0]                       impulse_time,
	input  logic [19:0]                       impulse_charge,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [15:0]                       hit_sensor,
	output logic signed [31:0]                time_digit,
	output logic [30:0]                       charge_digit,
	output logic [31:0]                       time_spread
);

	localparam int CNT_BITS_L = mhwd_pkg::CNT_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_OPEN, S_ACC1, S_ACC2, S_ACC3,
		S_DIV, S_DIVDONE, S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_SQDONE,
		S_TMUL, S_TRND, S_CRND, S_EMIT
	} state_t;

	typedef enum logic [1:0] {DV_DIGIT, DV_MEAN, DV_E2} div_op_t;

	state_t  state_q;
	div_op_t div_op_q;

	// configuration
	logic [19:0] thr_q;
	logic [31:0] origin_q;
	logic        tmode_q;
	logic [15:0] win_q, dead_q, tscale_q, cscale_q;
	logic [15:0] ts_eff, cs_eff;

	// hit state
	logic                   hit_open_q, crossing_seen_q;
	logic [SENSOR_BITS-1:0] open_sensor_q;
	logic [31:0]            hit_start_q, charge_sum_q, crossing_time_q;
	logic [47:0]            m1_q;
	logic [63:0]            m2_q;

	// latched item
	logic [SENSOR_BITS-1:0] sid_q;
	logic [31:0]            t_q;
	logic [19:0]            q_q;
	logic                   reopen_q, refused_q;

	// shared arithmetic
	logic [40:0]  mul_a;
	logic [19:0]  mul_b;
	logic [60:0]  prod_q;
	logic [71:0]  dvd_q;
	logic [31:0]  dvs_q, rem_q;
	logic [CNT_BITS_L-1:0] cnt_q;
	logic [63:0]  sv_q, sr_q, sb_q;

	// close results
	logic [16:0] digit_q;
	logic [31:0] mean_q;
	logic [55:0] e2_q;
	logic [47:0] lo_q;
	logic [40:0] t12_q;
	logic [31:0] spread_q;
	logic [31:0] td_q;
	logic [30:0] cd_q;
	logic        neg_q;

	// outputs
	logic        out_valid_q, status_q;
	logic [15:0] hit_sensor_q;
	logic [31:0] time_digit_q, time_spread_q;
	logic [30:0] charge_digit_q;

	// combinational helpers
	logic [SENSOR_BITS-1:0] sid_m;
	logic signed [33:0]     diff, win_s, late_s;
	logic                   in_win, late, pass_thr, accept, out_free;
	logic [31:0]            off_full;
	logic [OFFSET_BITS-1:0] off;
	logic [32:0]            sum_ext;
	logic [31:0]            sum_new;
	logic [48:0]            m1_ext;
	logic [64:0]            m2_ext;
	logic [32:0]            rem_sh;
	logic                   div_ge;
	logic [63:0]            sq_try;
	logic [63:0]            msq_full;
	logic [55:0]            msq, var_v;
	logic [63:0]            sp_full;
	logic signed [41:0]     delta;
	logic [40:0]            mag;
	logic [57:0]            r_full;
	logic [37:0]            r_td;
	logic [48:0]            c_full;
	logic [32:0]            c_cd;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign ts_eff = (tscale_q == 16'd0) ? 16'd1 : tscale_q;
	assign cs_eff = (cscale_q == 16'd0) ? 16'd1 : cscale_q;

	assign sid_m    = SENSOR_BITS'(32'(sensor_id));
	assign diff     = $signed({2'b00, impulse_time}) - $signed({2'b00, hit_start_q});
	assign win_s    = $signed(34'(win_q));
	assign late_s   = $signed(34'(win_q) + 34'(dead_q));
	assign in_win   = diff < win_s;
	assign late     = diff > late_s;
	assign pass_thr = charge_sum_q > 32'(thr_q);

	// offset of the impulse from hit start, saturating
	assign off_full = (t_q > hit_start_q) ? (t_q - hit_start_q) : 32'd0;
	assign off = ((off_full >> OFFSET_BITS) != 32'd0) ? '1 : off_full[OFFSET_BITS-1:0];

	assign sum_ext = 33'(charge_sum_q) + 33'(q_q);
	assign sum_new = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
	assign m1_ext  = 49'(m1_q) + 49'(prod_q[39:0]);
	assign m2_ext  = 65'(m2_q) + 65'(prod_q[59:0]);

	assign rem_sh = {rem_q, dvd_q[71]};
	assign div_ge = rem_sh >= 33'(dvs_q);
	assign sq_try = sr_q + sb_q;

	assign msq_full = 64'(lo_q) + (64'(prod_q[47:0]) << 16);
	assign msq      = msq_full[63:8];
	assign var_v    = (e2_q > msq) ? (e2_q - msq) : 56'd0;
	assign sp_full  = (sr_q + 64'd8) >> 4;

	assign delta = $signed({1'b0, t12_q}) - $signed({2'b00, origin_q, 8'h00});
	assign mag   = delta[41] ? 41'(-delta) : delta[40:0];

	assign r_full = (58'(prod_q[56:0]) + 58'h8_0000) >> 20;
	assign r_td   = r_full[37:0];
	assign c_full = (49'(prod_q[47:0]) + 49'h8000) >> 16;
	assign c_cd   = c_full[32:0];

	// shared multiplier operand selection
	always_comb begin
		mul_a = 41'(charge_sum_q);
		mul_b = 20'(cs_eff);
		case (state_q)
			S_ACC1: begin
				mul_a = 41'(off);
				mul_b = q_q;
			end
			S_ACC2: begin
				mul_a = prod_q[40:0];
				mul_b = 20'(off);
			end
			S_SQ0: begin
				mul_a = 41'(mean_q);
				mul_b = 20'(mean_q[15:0]);
			end
			S_SQ1: begin
				mul_a = 41'(mean_q);
				mul_b = 20'(mean_q[31:16]);
			end
			S_TMUL: begin
				mul_a = mag;
				mul_b = 20'(ts_eff);
			end
			default: begin
				mul_a = 41'(charge_sum_q);
				mul_b = 20'(cs_eff);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 61'(mul_a) * 61'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= mhwd_pkg::THRESHOLD_RST;
			origin_q <= mhwd_pkg::ORIGIN_RST;
			tmode_q  <= mhwd_pkg::TMODE_RST;
			win_q    <= mhwd_pkg::WINDOW_RST;
			dead_q   <= mhwd_pkg::DEAD_RST;
			tscale_q <= mhwd_pkg::TSCALE_RST;
			cscale_q <= mhwd_pkg::CSCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mhwd_pkg::CFG_CHARGE_THRESHOLD:    thr_q    <= cfg_data[19:0];
				mhwd_pkg::CFG_TIME_ORIGIN:         origin_q <= cfg_data;
				mhwd_pkg::CFG_THRESHOLD_TIME_MODE: tmode_q  <= cfg_data[0];
				mhwd_pkg::CFG_WINDOW_LENGTH:       win_q    <= cfg_data[15:0];
				mhwd_pkg::CFG_DEAD_LENGTH:         dead_q   <= cfg_data[15:0];
				mhwd_pkg::CFG_TIME_SCALE:          tscale_q <= cfg_data[15:0];
				mhwd_pkg::CFG_CHARGE_SCALE:        cscale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			div_op_q        <= DV_DIGIT;
			hit_open_q      <= 1'b0;
			crossing_seen_q <= 1'b0;
			open_sensor_q   <= '0;
			hit_start_q     <= '0;
			charge_sum_q    <= '0;
			crossing_time_q <= '0;
			m1_q            <= '0;
			m2_q            <= '0;
			reopen_q        <= 1'b0;
			refused_q       <= 1'b0;
			cnt_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sid_q     <= sid_m;
						t_q       <= impulse_time;
						q_q       <= impulse_charge;
						refused_q <= 1'b0;
						reopen_q  <= 1'b0;
						if (kind || (hit_open_q && sid_m == open_sensor_q && late)) begin
							if (hit_open_q) begin
								hit_open_q <= 1'b0;
								reopen_q   <= !kind;
								if (pass_thr) begin
									dvd_q    <= {56'd0, mhwd_pkg::DIGIT_NUM + (ts_eff >> 1)};
									dvs_q    <= 32'(ts_eff);
									rem_q    <= '0;
									cnt_q    <= '0;
									div_op_q <= DV_DIGIT;
									state_q  <= S_DIV;
								end else if (!kind) begin
									state_q <= S_OPEN;
								end
							end
						end else if (!hit_open_q) begin
							state_q <= S_OPEN;
						end else if (sid_m != open_sensor_q) begin
							refused_q <= 1'b1;
							state_q   <= S_EMIT;
						end else if (in_win) begin
							state_q <= S_ACC1;
						end
					end
				end
				S_OPEN: begin
					hit_open_q      <= 1'b1;
					open_sensor_q   <= sid_q;
					hit_start_q     <= t_q;
					charge_sum_q    <= '0;
					crossing_seen_q <= 1'b0;
					crossing_time_q <= '0;
					m1_q            <= '0;
					m2_q            <= '0;
					state_q         <= S_ACC1;
				end
				S_ACC1: state_q <= S_ACC2;
				S_ACC2: begin
					charge_sum_q <= sum_new;
					if (!crossing_seen_q && sum_new > 32'(thr_q)) begin
						crossing_seen_q <= 1'b1;
						crossing_time_q <= t_q;
					end
					m1_q    <= m1_ext[48] ? mhwd_pkg::M1_MAX : m1_ext[47:0];
					state_q <= S_ACC3;
				end
				S_ACC3: begin
					m2_q    <= m2_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_ext[63:0];
					state_q <= S_IDLE;
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					rem_q <= div_ge ? 32'(rem_sh - 33'(dvs_q)) : rem_sh[31:0];
					dvd_q <= {dvd_q[70:0], div_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS_L'(mhwd_pkg::DIV_STEPS - 1))
						state_q <= S_DIVDONE;
				end
				S_DIVDONE: begin
					rem_q <= '0;
					cnt_q <= '0;
					dvs_q <= charge_sum_q;
					case (div_op_q)
						DV_DIGIT: begin
							digit_q <= dvd_q[16:0];
							if (tmode_q) begin
								t12_q    <= {1'b0, crossing_seen_q ? crossing_time_q : hit_start_q,
									8'h00};
								spread_q <= 32'(dvd_q[16:0]);
								state_q  <= S_TMUL;
							end else begin
								dvd_q    <= {16'd0, m1_q, 8'h00};
								div_op_q <= DV_MEAN;
								state_q  <= S_DIV;
							end
						end
						DV_MEAN: begin
							mean_q   <= (dvd_q[71:32] != '0) ? 32'hFFFF_FFFF : dvd_q[31:0];
							dvd_q    <= {m2_q, 8'h00};
							div_op_q <= DV_E2;
							state_q  <= S_DIV;
						end
						DV_E2: begin
							// integer part clamps to 48 bits, fraction bits kept
							e2_q    <= {(dvd_q[71:56] != '0) ? mhwd_pkg::M1_MAX : dvd_q[55:8],
								dvd_q[7:0]};
							state_q <= S_SQ0;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SQ0: state_q <= S_SQ1;
				S_SQ1: begin
					lo_q    <= prod_q[47:0];
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					sv_q    <= 64'(var_v);
					sr_q    <= '0;
					sb_q    <= 64'h4000_0000_0000_0000;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sv_q >= sq_try) begin
						sv_q <= sv_q - sq_try;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q  <= sb_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS_L'(mhwd_pkg::SQRT_STEPS - 1))
						state_q <= S_SQDONE;
				end
				S_SQDONE: begin
					spread_q <= (sp_full < 64'(digit_q)) ? 32'(digit_q) : sp_full[31:0];
					t12_q    <= {1'b0, hit_start_q, 8'h00} + 41'(mean_q);
					state_q  <= S_TMUL;
				end
				S_TMUL: begin
					neg_q   <= delta[41];
					state_q <= S_TRND;
				end
				S_TRND: begin
					if (neg_q)
						td_q <= (r_td > 38'h0_8000_0000) ? 32'h8000_0000 : 32'(~r_td[31:0] + 32'd1);
					else
						td_q <= (r_td > 38'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_td[31:0];
					state_q <= S_CRND;
				end
				S_CRND: begin
					cd_q    <= (c_cd > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : c_cd[30:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (refused_q) begin
							status_q       <= 1'b1;
							hit_sensor_q   <= 16'(32'(sid_q));
							time_digit_q   <= '0;
							charge_digit_q <= '0;
							time_spread_q  <= '0;
							state_q        <= S_IDLE;
						end else begin
							status_q       <= 1'b0;
							hit_sensor_q   <= 16'(32'(open_sensor_q));
							time_digit_q   <= td_q;
							charge_digit_q <= cd_q;
							time_spread_q  <= spread_q;
							state_q        <= reopen_q ? S_OPEN : S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign hit_sensor   = hit_sensor_q;
	assign time_digit   = $signed(time_digit_q);
	assign charge_digit = charge_digit_q;
	assign time_spread  = time_spread_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < CNT_BITS_L'(mhwd_pkg::DIV_STEPS))
		else $error("divider ran past its last step");

	a_crossing_sum: assert property (@(posedge clk) disable iff (!arst_n)
		crossing_seen_q |-> charge_sum_q != 32'd0)
		else $error("crossing recorded with no charge");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> out_valid)
		else $error("result not presented after emit");

	a_acc_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC3 |=> state_q == S_IDLE)
		else $error("integration did not return to idle");

endmodule

FILE: verif/mhwd_checker.sv
// checker for the multi-hit window digitizer: mirrors the registers, predicts
// every digitized hit or refusal and compares it with the output channel
// depends on mhwd_pkg
module mhwd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [mhwd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              kind,
	input  logic [15:0]                       sensor_id,
	input  logic [31:0]                       impulse_time,
	input  logic [19:0]                       impulse_charge,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              status,
	input  logic [15:0]                       hit_sensor,
	input  logic signed [31:0]                time_digit,
	input  logic [30:0]                       charge_digit,
	input  logic [31:0]                       time_spread,
	output int                                fails,
	output int                                waiting,
	output int                                hits_seen
);

	typedef struct packed {
		logic        status;
		logic [15:0] sensor;
		logic [31:0] tdig;
		logic [30:0] qdig;
		logic [31:0] spread;
	} hit_rec_t;

	localparam longint unsigned OFF_MAX = 64'd65535;
	localparam longint unsigned MOM1_MAX = 64'hFFFF_FFFF_FFFF;

	hit_rec_t hit_q[$];

	// register mirror
	longint unsigned thr, origin, wlen, dlen, tscale, cscale;
	logic tmode;

	// open hit
	logic hit_open, crossed;
	longint unsigned open_sid, start_t, qsum, cross_t, mom1, mom2;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic start_hit(longint unsigned sid, longint unsigned t);
		hit_open = 1'b1;
		open_sid = sid;
		start_t = t;
		qsum = 0;
		crossed = 1'b0;
		cross_t = 0;
		mom1 = 0;
		mom2 = 0;
	endtask

	task automatic integrate(longint unsigned t, longint unsigned q);
		longint unsigned off, a1, a2;
		off = (t > start_t) ? t - start_t : 0;
		if (off > OFF_MAX) off = OFF_MAX;
		qsum += q;
		if (qsum > 64'hFFFF_FFFF) qsum = 64'hFFFF_FFFF;
		if (!crossed && qsum > thr) begin
			crossed = 1'b1;
			cross_t = t;
		end
		a1 = q * off;
		mom1 = (mom1 > MOM1_MAX - a1) ? MOM1_MAX : mom1 + a1;
		a2 = a1 * off;
		mom2 = (mom2 > ~64'd0 - a2) ? ~64'd0 : mom2 + a2;
	endtask

	// closes the hit and queues a digitized hit when it passes the threshold
	task automatic close_hit();
		longint unsigned ts, cs, digit, t12, spread, mag, r, cd;
		longint unsigned mean, e2h, e2, msq, var_t;
		longint signed delta;
		hit_rec_t h;
		ts = (tscale != 0) ? tscale : 1;
		cs = (cscale != 0) ? cscale : 1;
		digit = (4096 + ts / 2) / ts;
		hit_open = 1'b0;
		if (qsum <= thr) return;
		if (tmode) begin
			t12 = (crossed ? cross_t : start_t) << 8;
			spread = digit;
		end else begin
			mean = (mom1 << 8) / qsum;
			e2h = mom2 / qsum;
			if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
			if (e2h > MOM1_MAX) e2h = MOM1_MAX;
			e2 = (e2h << 8) + (((mom2 % qsum) << 8) / qsum);
			msq = (mean * mean) >> 8;
			var_t = (e2 > msq) ? e2 - msq : 0;
			spread = (int_sqrt(var_t) + 8) >> 4;
			if (spread < digit) spread = digit;
			t12 = (start_t << 8) + mean;
		end
		delta = $signed(t12) - $signed(origin << 8);
		mag = (delta < 0) ? -delta : delta;
		r = (mag * ts + 64'd524288) >> 20;
		if (delta < 0)
			h.tdig = (r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-r);
		else
			h.tdig = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(r);
		cd = (qsum * cs + 64'h8000) >> 16;
		if (cd > 64'h7FFF_FFFF) cd = 64'h7FFF_FFFF;
		if (spread > 64'hFFFF_FFFF) spread = 64'hFFFF_FFFF;
		h.status = 1'b0;
		h.sensor = open_sid[15:0];
		h.qdig = cd[30:0];
		h.spread = spread[31:0];
		hit_q.insert(hit_q.size(), h);
	endtask

	task automatic take_item(logic k, longint unsigned sid, longint unsigned t,
			longint unsigned q);
		longint signed diff;
		hit_rec_t h;
		if (k) begin
			if (hit_open) close_hit();
			return;
		end
		if (!hit_open) begin
			start_hit(sid, t);
			integrate(t, q);
			return;
		end
		if (sid != open_sid) begin
			h = '0;
			h.status = 1'b1;
			h.sensor = sid[15:0];
			hit_q.insert(hit_q.size(), h);
			return;
		end
		diff = $signed(t) - $signed(start_t);
		if (diff < $signed(wlen))
			integrate(t, q);
		else if (diff > $signed(wlen + dlen)) begin
			close_hit();
			start_hit(sid, t);
			integrate(t, q);
		end
	endtask

	task automatic compare_hit();
		hit_rec_t e;
		if (hit_q.size() == 0) begin
			$display("%0t: unexpected result status=%0d sensor=%0d", $time, status,
				hit_sensor);
			fails++;
			return;
		end
		e = hit_q.pop_front();
		hits_seen++;
		if (e.status !== status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, status);
			fails++;
		end
		if (e.sensor !== hit_sensor) begin
			$display("%0t: hit_sensor expected %0d actual %0d", $time, e.sensor,
				hit_sensor);
			fails++;
		end
		if (e.tdig !== time_digit) begin
			$display("%0t: time_digit expected %0d actual %0d", $time,
				$signed(e.tdig), time_digit);
			fails++;
		end
		if (e.qdig !== charge_digit) begin
			$display("%0t: charge_digit expected %0d actual %0d", $time, e.qdig,
				charge_digit);
			fails++;
		end
		if (e.spread !== time_spread) begin
			$display("%0t: time_spread expected %0d actual %0d", $time, e.spread,
				time_spread);
			fails++;
		end
	endtask

	initial begin
		fails = 0;
		hits_seen = 0;
	end

	assign waiting = hit_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = mhwd_pkg::THRESHOLD_RST;
			origin = mhwd_pkg::ORIGIN_RST;
			tmode = mhwd_pkg::TMODE_RST;
			wlen = mhwd_pkg::WINDOW_RST;
			dlen = mhwd_pkg::DEAD_RST;
			tscale = mhwd_pkg::TSCALE_RST;
			cscale = mhwd_pkg::CSCALE_RST;
			hit_open = 1'b0;
			start_hit(0, 0);
			hit_open = 1'b0;
			hit_q.delete();
		end else begin
			if (out_valid && !out_stall) compare_hit();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mhwd_pkg::CFG_CHARGE_THRESHOLD:    thr = cfg_data[19:0];
					mhwd_pkg::CFG_TIME_ORIGIN:         origin = cfg_data;
					mhwd_pkg::CFG_THRESHOLD_TIME_MODE: tmode = cfg_data[0];
					mhwd_pkg::CFG_WINDOW_LENGTH:       wlen = cfg_data[15:0];
					mhwd_pkg::CFG_DEAD_LENGTH:         dlen = cfg_data[15:0];
					mhwd_pkg::CFG_TIME_SCALE:          tscale = cfg_data[15:0];
					mhwd_pkg::CFG_CHARGE_SCALE:        cscale = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_item(kind, sensor_id, impulse_time, impulse_charge);
		end
	end

endmodule

FILE: verif/tb_top.sv
// testbench top for the multi-hit window digitizer: clock, reset, register
// phases and impulse streams; checking is done by mhwd_checker
// depends on mhwd_pkg, mhwd_checker and multi_hit_window_digitizer_top
module tb_top;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mhwd_pkg::CFG_IDX_BITS-1:0] cfg_index = mhwd_pkg::CFG_CHARGE_THRESHOLD;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [15:0] sensor_id = '0;
	logic [31:0] impulse_time = '0;
	logic [19:0] impulse_charge = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [15:0] hit_sensor;
	logic signed [31:0] time_digit;
	logic [30:0] charge_digit;
	logic [31:0] time_spread;

	int fails, waiting, hits_seen;
	int cycles = 0;
	int items_sent = 0;
	bit idle_on = 1'b1;
	bit rx_hold_req = 1'b0;
	int win_len = int'(mhwd_pkg::WINDOW_RST);
	int dead_len = int'(mhwd_pkg::DEAD_RST);

	multi_hit_window_digitizer_top DUT (.*);

	mhwd_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end else
				out_stall <= idle_on && ($urandom_range(99) < 16);
		end
	end

	task automatic write_reg(logic [mhwd_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == mhwd_pkg::CFG_WINDOW_LENGTH) win_len = val[15:0];
		if (idx == mhwd_pkg::CFG_DEAD_LENGTH) dead_len = val[15:0];
	endtask

	task automatic send_item(logic k, logic [15:0] sid, logic [31:0] t, logic [19:0] q);
		while (idle_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sensor_id <= sid;
		impulse_time <= t;
		impulse_charge <= q;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [19:0] pick_charge();
		case ($urandom_range(3))
			0:       return 20'($urandom);
			1:       return 20'($urandom_range(0, 40));
			default: return 20'($urandom_range(0, 600));
		endcase
	endfunction

	// mostly well-formed time-ordered streams, with foreign sensors and stray ends
	task automatic impulse_streams(int n);
		logic [15:0] sid;
		logic [31:0] t, hit_t;
		int r;
		sid = 16'($urandom);
		t = $urandom;
		hit_t = t;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) rx_hold_req = 1'b1;
			r = $urandom_range(99);
			if (r < 7)
				send_item(1'b0, sid ^ 16'($urandom_range(1, 65535)), $urandom, pick_charge());
			else if (r < 15) begin
				send_item(1'b1, 16'($urandom), $urandom, 20'($urandom));
				if ($urandom_range(1)) sid = 16'($urandom);
				t = $urandom;
				hit_t = t;
			end else begin
				case ($urandom_range(9))
					0:       t = hit_t + win_len + $urandom_range(0, dead_len);
					1, 2:    t = hit_t + win_len + dead_len + $urandom_range(1, 3000);
					3:       t = t - $urandom_range(0, 200);
					4:       t = t + $urandom_range(0, 300000);
					default: t = t + $urandom_range(0, win_len / 4 + 2);
				endcase
				if (t - hit_t > win_len + dead_len) hit_t = t;
				send_item(1'b0, sid, t, pick_charge());
			end
		end
		send_item(1'b1, sid, 32'hFFFF_FFFF, 20'hF_FFFF);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		send_item(1'b1, 16'h0000, 32'h0, 20'h0);
		send_item(1'b0, 16'h0000, 32'h0, 20'h0);
		send_item(1'b0, 16'h0000, 32'd100, 20'hF_FFFF);
		send_item(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
		send_item(1'b0, 16'h0000, 32'd850, 20'd50);
		send_item(1'b0, 16'h0000, 32'd2000, 20'd300);
		send_item(1'b0, 16'h0000, 32'd1990, 20'd400);
		send_item(1'b0, 16'h0000, 32'd2799, 20'd1);
		send_item(1'b1, 16'h1234, 32'h5555_5555, 20'hA_AAAA);
		send_item(1'b0, 16'hFFFF, 32'hFFFF_FF00, 20'd100);
		send_item(1'b1, 16'hFFFF, 32'h0, 20'h0);
		send_item(1'b0, 16'hAAAA, 32'hFFFF_FFF0, 20'd640);
		send_item(1'b0, 16'hAAAA, 32'hFFFF_FFFF, 20'd1);
		send_item(1'b0, 16'h5555, 32'h0, 20'd1);
		send_item(1'b1, 16'h0, 32'h0, 20'h0);
		send_item(1'b0, 16'h8001, 32'h8000_0000, 20'd640);
		send_item(1'b0, 16'h8001, 32'h8000_0400, 20'd641);
		send_item(1'b0, 16'h8001, 32'h8000_0400 + 32'd961, 20'd700);
		send_item(1'b1, 16'h8001, 32'h0, 20'h0);
		impulse_streams(190);
		drain();

		// weighted mean, upper extremes
		idle_on = 1'b0;
		write_reg(mhwd_pkg::CFG_THRESHOLD_TIME_MODE, 32'd0);
		write_reg(mhwd_pkg::CFG_CHARGE_THRESHOLD, 32'd0);
		write_reg(mhwd_pkg::CFG_TIME_ORIGIN, 32'hFFFF_FFFF);
		write_reg(mhwd_pkg::CFG_WINDOW_LENGTH, 32'd65535);
		write_reg(mhwd_pkg::CFG_DEAD_LENGTH, 32'd0);
		write_reg(mhwd_pkg::CFG_TIME_SCALE, 32'd65535);
		write_reg(mhwd_pkg::CFG_CHARGE_SCALE, 32'd65535);
		impulse_streams(60);
		idle_on = 1'b1;
		impulse_streams(130);
		drain();

		// weighted mean, highest threshold and smallest scales
		write_reg(mhwd_pkg::CFG_CHARGE_THRESHOLD, 32'hF_FFFF);
		write_reg(mhwd_pkg::CFG_TIME_ORIGIN, 32'h8000_0000);
		write_reg(mhwd_pkg::CFG_WINDOW_LENGTH, 32'd2000);
		write_reg(mhwd_pkg::CFG_DEAD_LENGTH, 32'd65535);
		write_reg(mhwd_pkg::CFG_TIME_SCALE, 32'd1);
		write_reg(mhwd_pkg::CFG_CHARGE_SCALE, 32'd1);
		impulse_streams(190);
		drain();

		// threshold crossing, zero window and zero scales
		write_reg(mhwd_pkg::CFG_THRESHOLD_TIME_MODE, 32'd1);
		write_reg(mhwd_pkg::CFG_CHARGE_THRESHOLD, 32'd100);
		write_reg(mhwd_pkg::CFG_TIME_ORIGIN, $urandom);
		write_reg(mhwd_pkg::CFG_WINDOW_LENGTH, 32'd0);
		write_reg(mhwd_pkg::CFG_DEAD_LENGTH, 32'd50);
		write_reg(mhwd_pkg::CFG_TIME_SCALE, 32'd0);
		write_reg(mhwd_pkg::CFG_CHARGE_SCALE, 32'd0);
		impulse_streams(190);
		drain();

		// random settings in both modes
		for (int p = 0; p < 2; p++) begin
			write_reg(mhwd_pkg::CFG_THRESHOLD_TIME_MODE, 32'(p));
			write_reg(mhwd_pkg::CFG_CHARGE_THRESHOLD, $urandom_range(0, 3000));
			write_reg(mhwd_pkg::CFG_TIME_ORIGIN, $urandom);
			write_reg(mhwd_pkg::CFG_WINDOW_LENGTH, $urandom_range(1, 4000));
			write_reg(mhwd_pkg::CFG_DEAD_LENGTH, $urandom_range(0, 1000));
			write_reg(mhwd_pkg::CFG_TIME_SCALE, $urandom_range(1, 65535));
			write_reg(mhwd_pkg::CFG_CHARGE_SCALE, $urandom_range(1, 65535));
			impulse_streams(95);
			drain();
		end

		$display("sent %0d items over six register settings, checked %0d results",
			items_sent, hits_seen);
		$display("both time modes, threshold and scale extremes, refusals and stalls");
		if (fails == 0 && waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
